FILE: rtl/core/dtsi_pkg.sv
// Shared types, codes and constant tables of the decimal text converter.
`timescale 1ns / 1ps

package dtsi_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_SYNTAX = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] MAX_SCALE = 3'd4;
  localparam logic [2:0] FRAC_SAT  = 3'd5;

  localparam logic [0:0] REG_FRAC_SCALE      = 1'b0;
  localparam logic [0:0] REG_UNSIGNED_TARGET = 1'b1;

  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  sign;
    logic        point;
    logic        started;
    logic [2:0]  frac_cnt;
    logic [1:0]  status;
    logic        ended;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '0;

  function automatic logic [2:0] eff_scale(input logic [2:0] fs);
    return (fs > MAX_SCALE) ? MAX_SCALE : fs;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] idx);
    logic [13:0] r;
    unique case (idx)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

  // Largest magnitude that still fits the target after scaling by pow10(idx).
  function automatic logic [63:0] lim_div(input logic uns, input logic [2:0] idx);
    logic [63:0] r;
    if (uns) begin
      unique case (idx)
        3'd0:    r = 64'd18446744073709551615;
        3'd1:    r = 64'd1844674407370955161;
        3'd2:    r = 64'd184467440737095516;
        3'd3:    r = 64'd18446744073709551;
        default: r = 64'd1844674407370955;
      endcase
    end else begin
      unique case (idx)
        3'd0:    r = 64'd9223372036854775807;
        3'd1:    r = 64'd922337203685477580;
        3'd2:    r = 64'd92233720368547758;
        3'd3:    r = 64'd9223372036854775;
        default: r = 64'd922337203685477;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/dtsi_char_if.sv
// Character input channel: one ASCII character and its end-of-text marker.
`timescale 1ns / 1ps

interface dtsi_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/core/dtsi_result_if.sv
// Result output channel: the scaled 64-bit value and its status code.
`timescale 1ns / 1ps

interface dtsi_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic [1:0]  status;

  modport source (output valid, output value_bits, output status, input ready);
  modport sink   (input valid, input value_bits, input status, output ready);
endinterface

FILE: rtl/core/dtsi_scan.sv
// Per-character parser step: updates the scan state for one character.
`timescale 1ns / 1ps

module dtsi_scan (
  input  dtsi_pkg::scan_state_t cur_i,
  input  logic [7:0]            char_i,
  input  logic [2:0]            scale_i,
  input  logic                  uns_i,
  output dtsi_pkg::scan_state_t nxt_o
);

  logic [3:0]  dig;
  logic [63:0] q_lim;
  logic [3:0]  r_lim;
  logic        over;
  logic [2:0]  fc_inc;
  logic [63:0] mag_x10;

  // (limit - d) / 10 exceeded, written as quotient and remainder of the limit.
  assign dig     = char_i[3:0];
  assign q_lim   = uns_i ? 64'd1844674407370955161 : 64'd922337203685477580;
  assign r_lim   = uns_i ? 4'd5 : 4'd7;
  assign over    = (cur_i.mag > q_lim) || ((cur_i.mag == q_lim) && (dig > r_lim));
  assign mag_x10 = {cur_i.mag[60:0], 3'b000} + {cur_i.mag[62:0], 1'b0} + {60'd0, dig};
  assign fc_inc  = (cur_i.point && (cur_i.frac_cnt < dtsi_pkg::FRAC_SAT)) ?
                   cur_i.frac_cnt + 3'd1 : cur_i.frac_cnt;

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.ended && !cur_i.status[1]) begin
      priority if (char_i == dtsi_pkg::CH_NUL) begin
        nxt_o.ended = 1'b1;
      end else if (char_i == dtsi_pkg::CH_DOT) begin
        if (cur_i.point) nxt_o.status = dtsi_pkg::ST_SYNTAX;
        else nxt_o.point = 1'b1;
      end else if ((char_i == dtsi_pkg::CH_MINUS) || (char_i == dtsi_pkg::CH_PLUS)) begin
        if ((cur_i.sign != dtsi_pkg::SIGN_NONE) || cur_i.started) begin
          nxt_o.status = dtsi_pkg::ST_SYNTAX;
        end else begin
          nxt_o.sign = (char_i == dtsi_pkg::CH_MINUS) ? dtsi_pkg::SIGN_MINUS
                                                      : dtsi_pkg::SIGN_PLUS;
        end
      end else if ((char_i >= dtsi_pkg::CH_ZERO) && (char_i <= dtsi_pkg::CH_NINE)) begin
        nxt_o.started  = 1'b1;
        nxt_o.frac_cnt = fc_inc;
        if (fc_inc > scale_i) begin
          if (dig != 4'd0) nxt_o.status = dtsi_pkg::ST_TRUNC;
        end else if (over) begin
          nxt_o.status = dtsi_pkg::ST_RANGE;
        end else begin
          nxt_o.mag = mag_x10;
        end
      end else begin
        nxt_o.status = dtsi_pkg::ST_SYNTAX;
      end
    end
  end

endmodule

FILE: rtl/core/dtsi_finish.sv
// End-of-text step: pads to the scale, applies the sign and forms the result.
`timescale 1ns / 1ps

module dtsi_finish (
  input  dtsi_pkg::scan_state_t st_i,
  input  logic [2:0]            scale_i,
  input  logic                  uns_i,
  output logic [63:0]           value_o,
  output logic [1:0]            status_o
);

  logic [2:0]  pad_idx;
  logic        need_pad;
  logic [63:0] x10;
  logic [63:0] x100;
  logic [63:0] x1000;
  logic [63:0] x10000;
  logic [63:0] padded;
  logic [63:0] v;
  logic [1:0]  s;

  assign need_pad = (st_i.frac_cnt < scale_i);
  assign pad_idx  = scale_i - st_i.frac_cnt;

  // Constant multiplies by the powers of ten, built from shifts, adds and subtracts.
  // Only the low 64 bits matter: an overflowing product is out of range anyway.
  assign x10    = {st_i.mag[60:0], 3'b000} + {st_i.mag[62:0], 1'b0};
  assign x100   = {st_i.mag[57:0], 6'd0} + {st_i.mag[58:0], 5'd0} + {st_i.mag[61:0], 2'd0};
  assign x1000  = {st_i.mag[53:0], 10'd0} - {st_i.mag[59:0], 4'd0} - {st_i.mag[60:0], 3'd0};
  assign x10000 = {st_i.mag[50:0], 13'd0} + {st_i.mag[53:0], 10'd0} +
                  {st_i.mag[54:0], 9'd0} + {st_i.mag[55:0], 8'd0} + {st_i.mag[59:0], 4'd0};

  always_comb begin
    unique case (pad_idx)
      3'd1:    padded = x10;
      3'd2:    padded = x100;
      3'd3:    padded = x1000;
      3'd4:    padded = x10000;
      default: padded = st_i.mag;
    endcase
  end

  always_comb begin
    v = st_i.mag;
    s = st_i.status;
    if (!s[1] && need_pad) begin
      if (st_i.mag > dtsi_pkg::lim_div(uns_i, pad_idx)) s = dtsi_pkg::ST_RANGE;
      else v = padded;
    end
    if (!s[1] && (st_i.sign == dtsi_pkg::SIGN_MINUS)) begin
      if (uns_i) s = dtsi_pkg::ST_RANGE;
      else v = 64'd0 - v;
    end
    value_o  = s[1] ? 64'd0 : v;
    status_o = s;
  end

endmodule

FILE: rtl/core/decimal_text_to_scaled_int64_top.sv
// Top level of the decimal text to scaled 64-bit integer converter.
//
//   Channel   Direction  Beat contents                     Accepted when
//   char_in   in         char_code[7:0], last_char         valid && ready
//   res_out   out        value_bits[63:0], status[1:0]     valid && ready
//   APB cfg   in/out     frac_scale @0x0, unsigned_target  psel && penable && pwrite
//                        @0x4 (32-bit data)
//
// One character beat is taken every cycle, except that a last character waits
// for room in the finish register. A character sits in the input register
// while the parser updates the scan state; on the last character the finished
// state moves to a finish register, where the padding by a power of ten
// (shifts, adds and subtracts) and the sign step run, and the result moves on
// from there into the output register.
// Reset clears the scan state, the valid flags and both configuration
// registers. A stalled result stalls only last characters; other characters
// keep flowing while the finish and output registers are full.
`timescale 1ns / 1ps

module decimal_text_to_scaled_int64_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dtsi_char_if.sink            char_in,
  dtsi_result_if.source        res_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers.
  logic [2:0] frac_scale_q;
  logic       unsigned_q;
  logic [2:0] scale_eff;
  logic       cfg_we;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign scale_eff = dtsi_pkg::eff_scale(frac_scale_q);
  assign prdata    = (paddr[2] == dtsi_pkg::REG_UNSIGNED_TARGET) ?
                     {31'd0, unsigned_q} : {29'd0, frac_scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_scale_q <= 3'd0;
      unsigned_q   <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == dtsi_pkg::REG_FRAC_SCALE) frac_scale_q <= pwdata[2:0];
      else unsigned_q <= pwdata[0];
    end
  end

  // Input register holding one character beat.
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Finish register holding the scan state of a completed text.
  logic                  fin_vld_q;
  dtsi_pkg::scan_state_t fin_q;

  // Output register.
  logic        out_vld_q;
  logic [63:0] out_value_q;
  logic [1:0]  out_status_q;

  dtsi_pkg::scan_state_t state_q;
  dtsi_pkg::scan_state_t state_d;

  logic        fin_adv;
  logic        fin_free;
  logic        in_consume;
  logic [63:0] fin_value;
  logic [1:0]  fin_status;

  // Ready runs back from the output: a last character needs room in the
  // finish register, any other character is consumed at once.
  assign fin_adv    = fin_vld_q && (!out_vld_q || res_out.ready);
  assign fin_free   = !fin_vld_q || fin_adv;
  assign in_consume = in_vld_q && (!in_last_q || fin_free);
  assign char_in.ready = !in_vld_q || in_consume;

  dtsi_scan u_scan (
    .cur_i   (state_q),
    .char_i  (in_char_q),
    .scale_i (scale_eff),
    .uns_i   (unsigned_q),
    .nxt_o   (state_d)
  );

  dtsi_finish u_finish (
    .st_i     (fin_q),
    .scale_i  (scale_eff),
    .uns_i    (unsigned_q),
    .value_o  (fin_value),
    .status_o (fin_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= dtsi_pkg::SCAN_CLEAR;
    end else begin
      if (char_in.valid && char_in.ready) in_vld_q <= 1'b1;
      else if (in_consume) in_vld_q <= 1'b0;

      if (in_consume) begin
        state_q <= in_last_q ? dtsi_pkg::SCAN_CLEAR : state_d;
      end

      if (in_consume && in_last_q) fin_vld_q <= 1'b1;
      else if (fin_adv) fin_vld_q <= 1'b0;

      if (fin_adv) out_vld_q <= 1'b1;
      else if (res_out.ready) out_vld_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (char_in.valid && char_in.ready) begin
      in_char_q <= char_in.char_code;
      in_last_q <= char_in.last_char;
    end
    if (in_consume && in_last_q) fin_q <= state_d;
    if (fin_adv) begin
      out_value_q  <= fin_value;
      out_status_q <= fin_status;
    end
  end

  assign res_out.valid      = out_vld_q;
  assign res_out.value_bits = out_value_q;
  assign res_out.status     = out_status_q;

  // A pending finish entry is never dropped while the output is stalled.
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !fin_adv |=> fin_vld_q)
    else $error("finish entry lost under stall");

  // The scan state starts fresh after the last character of a text.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_consume && in_last_q |=> state_q == dtsi_pkg::SCAN_CLEAR)
    else $error("scan state not cleared after last character");

  // Error results carry a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q[1] |-> out_value_q == 64'd0)
    else $error("error result with nonzero value");

  // The fractional digit count saturates.
  a_frac_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.frac_cnt <= dtsi_pkg::FRAC_SAT)
    else $error("fractional digit count past saturation");

endmodule
